@@ rtl/assert_macros.svh @@
// Assertion helpers; every user module has clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ODMT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ODMT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

@@ rtl/odmt_pkg.sv @@
package odmt_pkg;

	localparam int FRAME_SIZE_W = 12;
	localparam int DEPTH_W      = 16;
	localparam int BASE_W       = 24;
	localparam int VERTEX_W     = 25;
	localparam int CFG_DATA_W   = 24;
	localparam int CFG_INDEX_W  = 2;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam int CELL_FIFO_DEPTH = 4;

	localparam logic [FRAME_SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd960;
	localparam logic [FRAME_SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd540;
	localparam logic [DEPTH_W-1:0]      THRESHOLD_RST    = 16'd150;
	localparam logic [BASE_W-1:0]       VERTEX_BASE_RST  = 24'd0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT,
		REG_DEPTH_THRESHOLD,
		REG_VERTEX_BASE
	} reg_index_t;

endpackage

@@ rtl/odmt_sample_if.sv @@
interface odmt_sample_if;
	logic                              valid;
	logic                              ready;
	logic [odmt_pkg::DEPTH_W-1:0]      depth_mm;
	logic                              frame_start;

	modport source (output valid, output depth_mm, output frame_start, input ready);
	modport sink (input valid, input depth_mm, input frame_start, output ready);
endinterface

@@ rtl/odmt_tri_if.sv @@
interface odmt_tri_if;
	logic                           valid;
	logic                           ready;
	logic [odmt_pkg::VERTEX_W-1:0]  vertex_first;
	logic [odmt_pkg::VERTEX_W-1:0]  vertex_second;
	logic [odmt_pkg::VERTEX_W-1:0]  vertex_third;
	logic                           lower_right;
	logic                           last;

	modport source (output valid, output vertex_first, output vertex_second,
		output vertex_third, output lower_right, output last, input ready);
	modport sink (input valid, input vertex_first, input vertex_second,
		input vertex_third, input lower_right, input last, output ready);
endinterface

@@ rtl/organized_depth_mesh_triangulator.sv @@
// A sample's first triangle passes the stage-1, queue, stage-2 and output
// registers. Throughput: one sample per cycle in while the cell queue has room;
// one triangle per cycle out while the sink is ready, a cell's pair in turn.
// A 4-entry cell queue between the classifier and the emitter absorbs bursts.
// Reset (arst_n low, async): position, neighbor depths, queue and output clear;
// the column store is not cleared, registers return to 960x540, 150 mm, base 0.
module organized_depth_mesh_triangulator #(
	parameter int MAX_WIDTH  = odmt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = odmt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	odmt_sample_if.sink                          samples,
	odmt_tri_if.source                           triangles,
	input  logic                                 wr_en,
	input  logic [odmt_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [odmt_pkg::CFG_DATA_W-1:0]      wr_data
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int SW  = $clog2(MAX_WIDTH+1);
	localparam int SH  = $clog2(MAX_HEIGHT+1);
	localparam int FW  = odmt_pkg::FRAME_SIZE_W;
	localparam int ZWW = (SW > FW) ? SW : FW;
	localparam int ZHW = (SH > FW) ? SH : FW;
	localparam int EW  = CW + RW + 2;

	logic [FW-1:0]                   frame_width_q;
	logic [FW-1:0]                   frame_height_q;
	logic [odmt_pkg::DEPTH_W-1:0]    threshold_q;
	logic [odmt_pkg::BASE_W-1:0]     vertex_base_q;

	logic [SW-1:0] width_eff;
	logic [SH-1:0] height_eff;

	logic          cell_push, cell_full, cell_pop, cell_empty;
	logic [EW-1:0] push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= odmt_pkg::FRAME_WIDTH_RST;
			frame_height_q <= odmt_pkg::FRAME_HEIGHT_RST;
			threshold_q    <= odmt_pkg::THRESHOLD_RST;
			vertex_base_q  <= odmt_pkg::VERTEX_BASE_RST;
		end else if (wr_en) begin
			unique case (odmt_pkg::reg_index_t'(wr_index))
				odmt_pkg::REG_FRAME_WIDTH:     frame_width_q  <= wr_data[FW-1:0];
				odmt_pkg::REG_FRAME_HEIGHT:    frame_height_q <= wr_data[FW-1:0];
				odmt_pkg::REG_DEPTH_THRESHOLD: threshold_q    <= wr_data[odmt_pkg::DEPTH_W-1:0];
				odmt_pkg::REG_VERTEX_BASE:     vertex_base_q  <= wr_data[odmt_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// sizes clamp to [2, MAX]
	always_comb begin
		if (ZWW'(frame_width_q) < ZWW'(2)) begin
			width_eff = SW'(2);
		end else if (ZWW'(frame_width_q) > ZWW'(MAX_WIDTH)) begin
			width_eff = SW'(MAX_WIDTH);
		end else begin
			width_eff = SW'(frame_width_q);
		end
		if (ZHW'(frame_height_q) < ZHW'(2)) begin
			height_eff = SH'(2);
		end else if (ZHW'(frame_height_q) > ZHW'(MAX_HEIGHT)) begin
			height_eff = SH'(MAX_HEIGHT);
		end else begin
			height_eff = SH'(frame_height_q);
		end
	end

	odmt_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.samples            (samples),
		.frame_width        (width_eff),
		.frame_height       (height_eff),
		.depth_threshold_mm (threshold_q),
		.cell_push          (cell_push),
		.cell_data          (push_data),
		.cell_full          (cell_full)
	);

	odmt_cell_fifo #(
		.DATA_W (EW),
		.DEPTH  (odmt_pkg::CELL_FIFO_DEPTH)
	) u_cell_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cell_push),
		.push_data (push_data),
		.full      (cell_full),
		.pop       (cell_pop),
		.pop_data  (pop_data),
		.empty     (cell_empty)
	);

	odmt_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_width (width_eff),
		.vertex_base (vertex_base_q),
		.cell_pop    (cell_pop),
		.cell_data   (pop_data),
		.cell_empty  (cell_empty),
		.triangles   (triangles)
	);

endmodule

@@ rtl/odmt_front.sv @@
module odmt_front #(
	parameter int MAX_WIDTH  = odmt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = odmt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	odmt_sample_if.sink                              samples,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]           frame_width,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]          frame_height,
	input  logic [odmt_pkg::DEPTH_W-1:0]             depth_threshold_mm,
	output logic                                     cell_push,
	output logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] cell_data,
	input  logic                                     cell_full
);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int SW  = $clog2(MAX_WIDTH+1);
	localparam int SH  = $clog2(MAX_HEIGHT+1);
	localparam int CCW = (CW + 1 > SW) ? CW + 1 : SW;
	localparam int RCW = (RW + 1 > SH) ? RW + 1 : SH;
	localparam int DW  = odmt_pkg::DEPTH_W;

	function automatic logic [DW-1:0] absdiff(input logic [DW-1:0] a, input logic [DW-1:0] b);
		absdiff = (a > b) ? a - b : b - a;
	endfunction

	function automatic logic tri_ok(input logic [DW-1:0] a, input logic [DW-1:0] b,
		input logic [DW-1:0] c, input logic [DW-1:0] thr);
		tri_ok = (a != '0) && (b != '0) && (c != '0) &&
			(absdiff(a, b) <= thr) && (absdiff(b, c) <= thr) && (absdiff(a, c) <= thr);
	endfunction

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [DW-1:0] prev_q;
	logic [DW-1:0] diag_q;

	logic          valid_s1;
	logic          cell_s1;
	logic [CW-1:0] i_s1;
	logic [RW-1:0] j_s1;
	logic [DW-1:0] depth_s1;
	logic [DW-1:0] prev_s1;
	logic [DW-1:0] left_s1;

	logic [DW-1:0] depth_mem [MAX_HEIGHT];

	logic [CW-1:0] col, col_nxt;
	logic [RW-1:0] row, row_nxt;
	logic          in_cell, row_wrap, col_wrap;
	logic          accept, leave, ok_ul, ok_lr, want_push;

	assign col = samples.frame_start ? '0 : col_q;
	assign row = samples.frame_start ? '0 : row_q;

	assign in_cell = (col != '0) && (row != '0) &&
		(CCW'(col) < CCW'(frame_width)) && (RCW'(row) < RCW'(frame_height));

	assign row_wrap = (RCW'(row) + RCW'(1)) >= RCW'(frame_height);
	assign col_wrap = (CCW'(col) + CCW'(1)) >= CCW'(frame_width);
	assign row_nxt  = row_wrap ? '0 : row + RW'(1);
	assign col_nxt  = row_wrap ? (col_wrap ? '0 : col + CW'(1)) : col;

	// corners: ul = old store entry of previous sample, ur = previous sample,
	// ll = store entry, lr = this sample
	assign ok_ul = tri_ok(prev_s1, diag_q, left_s1, depth_threshold_mm);
	assign ok_lr = tri_ok(left_s1, depth_s1, prev_s1, depth_threshold_mm);

	assign want_push     = valid_s1 && cell_s1 && (ok_ul || ok_lr);
	assign cell_push     = want_push && !cell_full;
	assign cell_data     = {i_s1, j_s1, ok_ul, ok_lr};
	assign leave         = valid_s1 && (!want_push || !cell_full);
	assign samples.ready = !valid_s1 || leave;
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			prev_q   <= '0;
			diag_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				col_q  <= col_nxt;
				row_q  <= row_nxt;
				prev_q <= samples.depth_mm;
			end
			if (leave) begin
				diag_q <= left_s1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (leave) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_s1  <= in_cell;
			i_s1     <= col - CW'(1);
			j_s1     <= row - RW'(1);
			depth_s1 <= samples.depth_mm;
			prev_s1  <= prev_q;
		end
	end

	// column store: read-first, the old entry is the left neighbor
	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1        <= depth_mem[row];
			depth_mem[row] <= samples.depth_mm;
		end
	end

endmodule

@@ rtl/odmt_cell_fifo.sv @@
`include "assert_macros.svh"

module odmt_cell_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = odmt_pkg::CELL_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH+1);

	logic [DATA_W-1:0] entries_q [DEPTH];
	logic [AW-1:0]     wr_ptr_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [NW-1:0]     count_q;

	assign full     = (count_q == NW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	`ODMT_NEVER(a_no_push_full, push && full, "cell queue overflow")
	`ODMT_NEVER(a_no_pop_empty, pop && empty, "cell queue underflow")

endmodule

@@ rtl/odmt_back.sv @@
`include "assert_macros.svh"

module odmt_back #(
	parameter int MAX_WIDTH  = odmt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = odmt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]           frame_width,
	input  logic [odmt_pkg::BASE_W-1:0]              vertex_base,
	output logic                                     cell_pop,
	input  logic [$clog2(MAX_WIDTH)+$clog2(MAX_HEIGHT)+1:0] cell_data,
	input  logic                                     cell_empty,
	odmt_tri_if.source                               triangles
);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int SW = $clog2(MAX_WIDTH+1);
	localparam int PW = RW + SW;
	localparam int VW = odmt_pkg::VERTEX_W;

	logic [CW-1:0] i_in;
	logic [RW-1:0] j_in;
	logic          ul_in, lr_in;
	logic [PW-1:0] prod;

	logic          valid_s2;
	logic          pend_ul_s2;
	logic          pend_lr_s2;
	logic [CW-1:0] i_s2;
	logic [VW-1:0] rowoff_s2;

	logic          out_valid_q;
	logic [VW-1:0] first_q, second_q, third_q;
	logic          lower_right_q, last_q;

	logic [VW-1:0] v_ij, v_i1j, v_ij1, v_i1j1;
	logic          can_load, emit, final_beat, s2_free;

	assign {i_in, j_in, ul_in, lr_in} = cell_data;
	assign prod = PW'(j_in) * PW'(frame_width);

	assign v_ij   = VW'(vertex_base) + rowoff_s2 + VW'(i_s2);
	assign v_i1j  = v_ij + VW'(1);
	assign v_ij1  = v_ij + VW'(frame_width);
	assign v_i1j1 = v_ij1 + VW'(1);

	assign can_load   = !out_valid_q || triangles.ready;
	assign emit       = valid_s2 && can_load;
	assign final_beat = emit && (!pend_ul_s2 || !pend_lr_s2);
	assign s2_free    = !valid_s2 || final_beat;
	assign cell_pop   = s2_free && !cell_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			pend_ul_s2  <= 1'b0;
			pend_lr_s2  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cell_pop) begin
				valid_s2   <= 1'b1;
				pend_ul_s2 <= ul_in;
				pend_lr_s2 <= lr_in;
			end else begin
				if (final_beat) begin
					valid_s2 <= 1'b0;
				end
				if (emit && pend_ul_s2) begin
					pend_ul_s2 <= 1'b0;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (triangles.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cell_pop) begin
			i_s2      <= i_in;
			rowoff_s2 <= VW'(prod);
		end
		if (emit) begin
			if (pend_ul_s2) begin
				// upper-left: right, self, below
				first_q       <= v_i1j;
				second_q      <= v_ij;
				third_q       <= v_ij1;
				lower_right_q <= 1'b0;
				last_q        <= !pend_lr_s2;
			end else begin
				// lower-right: below, diagonal, right
				first_q       <= v_ij1;
				second_q      <= v_i1j1;
				third_q       <= v_i1j;
				lower_right_q <= 1'b1;
				last_q        <= 1'b1;
			end
		end
	end

	assign triangles.valid         = out_valid_q;
	assign triangles.vertex_first  = first_q;
	assign triangles.vertex_second = second_q;
	assign triangles.vertex_third  = third_q;
	assign triangles.lower_right   = lower_right_q;
	assign triangles.last          = last_q;

	`ODMT_ASSERT(a_cell_has_work, valid_s2 |-> (pend_ul_s2 || pend_lr_s2), "empty cell held")
	`ODMT_ASSERT(a_pair_order, triangles.valid && triangles.ready && !triangles.last |=> triangles.valid && triangles.lower_right, "lower-right beat missing after first of pair")

endmodule
